### rtl/sam_pkg.sv
// Package with shared constants and the controller state type of the suffix automaton.
package sam_pkg;

  localparam int unsigned MaxSymbolsDef   = 1024;
  localparam int unsigned AlphabetSizeDef = 26;
  localparam int unsigned SymW            = 5;
  localparam int unsigned CountW          = 20;
  localparam int unsigned InDataW         = 8;
  localparam int unsigned OutDataW        = 24;
  localparam logic [CountW-1:0] CountMax  = '1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LEN,
    S_WALK,
    S_LQ,
    S_CMP,
    S_CL1,
    S_CL2,
    S_CL3,
    S_COPY,
    S_RED,
    S_DONE
  } sam_state_e;

endpackage

### rtl/sam_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module sam_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/suffix_automaton_distinct_substrings_top.sv
// Top level: online suffix automaton with a running count of distinct substrings.
// Each symbol walks the suffix links from the last state, adding one transition per step,
// until it meets an existing transition or the walk reaches the root; a clone copies every
// transition of the cloned state and then redirects transitions along the suffix links.
// Ignored symbols answer in the cycle after accept. One symbol is in work at a time. Reset is
// asynchronous; the transition memory is then cleared one entry a cycle, accepting no symbol.
module suffix_automaton_distinct_substrings_top #(
  parameter int unsigned MAX_SYMBOLS   = sam_pkg::MaxSymbolsDef,
  parameter int unsigned ALPHABET_SIZE = sam_pkg::AlphabetSizeDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [sam_pkg::InDataW-1:0]   s_axis_tdata,   // symbol[4:0]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [sam_pkg::OutDataW-1:0]  m_axis_tdata    // distinct_count[19:0], store_full[20]
);

  localparam int unsigned NumStates = 2 * MAX_SYMBOLS;
  localparam int unsigned SW        = $clog2(NumStates);
  localparam int unsigned CW        = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int unsigned TAW       = SW + CW;
  localparam int unsigned TDepth    = NumStates << CW;
  localparam logic [SW-1:0] Root    = SW'(1);
  localparam logic [CW-1:0] LastSym = CW'(ALPHABET_SIZE - 1);

  sam_pkg::sam_state_e state_q, state_d;

  logic [TAW-1:0]  clr_q, clr_d;
  logic [CW-1:0]   c_q, c_d, k_q, k_d;
  logic [SW-1:0]   p_q, p_d, q_q, q_d, cur_q, cur_d, nq_q, nq_d;
  logic [SW-1:0]   lenp_q, lenp_d, lencur_q, lencur_d, linklen_q, linklen_d;
  logic [SW-1:0]   last_q, last_d;
  logic [SW:0]     cnt_q, cnt_d;
  logic            clone_q, clone_d;
  logic [sam_pkg::CountW-1:0] total_q, total_d, ocount_q, ocount_d;
  logic            ofull_q, ofull_d, ovalid_q, ovalid_d;

  logic            tr_we, len_we, lk_we;
  logic [TAW-1:0]  tr_waddr, tr_raddr;
  logic [SW-1:0]   tr_wdata, tr_rdata;
  logic [SW-1:0]   len_waddr, len_raddr, len_wdata, len_rdata;
  logic [SW-1:0]   lk_waddr, lk_raddr, lk_wdata, lk_rdata;

  logic [sam_pkg::SymW-1:0] sym;
  logic            accept, in_range, is_full, walk_free, walk_end, red_hit, solid, copy_end;
  logic [SW-1:0]   lenp_inc, gain;
  logic [sam_pkg::CountW:0] sum;

  sam_ram #(.Width(SW), .Depth(TDepth)) u_trans (
    .clk_i, .we_i(tr_we), .waddr_i(tr_waddr), .wdata_i(tr_wdata),
    .raddr_i(tr_raddr), .rdata_o(tr_rdata)
  );
  sam_ram #(.Width(SW), .Depth(NumStates)) u_len (
    .clk_i, .we_i(len_we), .waddr_i(len_waddr), .wdata_i(len_wdata),
    .raddr_i(len_raddr), .rdata_o(len_rdata)
  );
  sam_ram #(.Width(SW), .Depth(NumStates)) u_link (
    .clk_i, .we_i(lk_we), .waddr_i(lk_waddr), .wdata_i(lk_wdata),
    .raddr_i(lk_raddr), .rdata_o(lk_rdata)
  );

  assign sym           = s_axis_tdata[sam_pkg::SymW-1:0];
  assign s_axis_tready = (state_q == sam_pkg::S_IDLE) && (!ovalid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_range      = 32'(sym) < ALPHABET_SIZE;
  assign is_full       = (32'(cnt_q) + 32'd2) > (NumStates - 1);
  assign walk_free     = (tr_rdata == '0);
  assign walk_end      = (lk_rdata == '0);
  assign red_hit       = (tr_rdata == q_q);
  assign lenp_inc      = lenp_q + SW'(1);
  assign solid         = (lenp_inc == len_rdata);
  assign copy_end      = (k_q == LastSym);
  assign gain          = lencur_q - linklen_q;
  assign sum           = {1'b0, total_q} + (sam_pkg::CountW + 1)'(gain);

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {3'b000, ofull_q, ocount_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sam_pkg::S_CLEAR: if (clr_q == '1) state_d = sam_pkg::S_IDLE;
      sam_pkg::S_IDLE:  if (accept && in_range && !is_full) state_d = sam_pkg::S_LEN;
      sam_pkg::S_LEN:   state_d = sam_pkg::S_WALK;
      sam_pkg::S_WALK: begin
        if (!walk_free) state_d = sam_pkg::S_LQ;
        else if (walk_end) state_d = sam_pkg::S_DONE;
      end
      sam_pkg::S_LQ:    state_d = sam_pkg::S_CMP;
      sam_pkg::S_CMP:   state_d = solid ? sam_pkg::S_DONE : sam_pkg::S_CL1;
      sam_pkg::S_CL1:   state_d = sam_pkg::S_CL2;
      sam_pkg::S_CL2:   state_d = sam_pkg::S_CL3;
      sam_pkg::S_CL3:   state_d = sam_pkg::S_COPY;
      sam_pkg::S_COPY:  if (copy_end) state_d = sam_pkg::S_RED;
      sam_pkg::S_RED:   if (!red_hit || walk_end) state_d = sam_pkg::S_DONE;
      sam_pkg::S_DONE:  state_d = sam_pkg::S_IDLE;
      default:          state_d = sam_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    clr_d = clr_q; c_d = c_q; k_d = k_q; p_d = p_q; q_d = q_q; cur_d = cur_q; nq_d = nq_q;
    lenp_d = lenp_q; lencur_d = lencur_q; linklen_d = linklen_q; last_d = last_q;
    cnt_d = cnt_q; clone_d = clone_q; total_d = total_q;
    ocount_d = ocount_q; ofull_d = ofull_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    tr_we = 1'b0; tr_waddr = {p_q, c_q}; tr_wdata = cur_q; tr_raddr = {p_q, c_q};
    len_we = 1'b0; len_waddr = cur_q; len_wdata = lencur_q; len_raddr = p_q;
    lk_we = 1'b0; lk_waddr = cur_q; lk_wdata = Root; lk_raddr = p_q;
    unique case (state_q)
      sam_pkg::S_CLEAR: begin
        tr_we = 1'b1; tr_waddr = clr_q; tr_wdata = '0;
        len_we = 1'b1; len_waddr = Root; len_wdata = '0;
        lk_we = 1'b1; lk_waddr = Root; lk_wdata = '0;
        clr_d = clr_q + TAW'(1);
      end
      sam_pkg::S_IDLE: begin
        len_raddr = last_q;
        if (accept) begin
          c_d = CW'(sym);
          p_d = last_q;
          cur_d = cnt_q[SW-1:0] + SW'(1);
          nq_d = cnt_q[SW-1:0] + SW'(2);
          clone_d = 1'b0;
          if (!in_range || is_full) begin
            ovalid_d = 1'b1;
            ocount_d = total_q;
            ofull_d = in_range;
          end
        end
      end
      sam_pkg::S_LEN: begin
        lencur_d = len_rdata + SW'(1);
        len_we = 1'b1; len_waddr = cur_q; len_wdata = len_rdata + SW'(1);
      end
      sam_pkg::S_WALK: begin
        len_raddr = p_q;
        if (walk_free) begin
          tr_we = 1'b1;
          p_d = lk_rdata;
          tr_raddr = {lk_rdata, c_q};
          lk_raddr = lk_rdata;
          if (walk_end) begin
            lk_we = 1'b1; lk_waddr = cur_q; lk_wdata = Root;
            linklen_d = '0;
          end
        end else begin
          q_d = tr_rdata;
        end
      end
      sam_pkg::S_LQ: begin
        lenp_d = len_rdata;
        len_raddr = q_q;
      end
      sam_pkg::S_CMP: begin
        if (solid) begin
          lk_we = 1'b1; lk_waddr = cur_q; lk_wdata = q_q;
          linklen_d = len_rdata;
        end else begin
          clone_d = 1'b1;
          len_we = 1'b1; len_waddr = nq_q; len_wdata = lenp_inc;
          linklen_d = lenp_inc;
          lk_raddr = q_q;
        end
      end
      sam_pkg::S_CL1: begin
        lk_we = 1'b1; lk_waddr = nq_q; lk_wdata = lk_rdata;
      end
      sam_pkg::S_CL2: begin
        lk_we = 1'b1; lk_waddr = q_q; lk_wdata = nq_q;
      end
      sam_pkg::S_CL3: begin
        lk_we = 1'b1; lk_waddr = cur_q; lk_wdata = nq_q;
        tr_raddr = {q_q, CW'(0)};
        k_d = '0;
      end
      sam_pkg::S_COPY: begin
        tr_we = 1'b1; tr_waddr = {nq_q, k_q}; tr_wdata = tr_rdata;
        if (copy_end) begin
          tr_raddr = {p_q, c_q};
        end else begin
          tr_raddr = {q_q, k_q + CW'(1)};
          k_d = k_q + CW'(1);
        end
      end
      sam_pkg::S_RED: begin
        if (red_hit) begin
          tr_we = 1'b1; tr_waddr = {p_q, c_q}; tr_wdata = nq_q;
          p_d = lk_rdata;
          tr_raddr = {lk_rdata, c_q};
          lk_raddr = lk_rdata;
        end
      end
      sam_pkg::S_DONE: begin
        total_d = sum[sam_pkg::CountW] ? sam_pkg::CountMax : sum[sam_pkg::CountW-1:0];
        last_d = cur_q;
        cnt_d = cnt_q + (SW + 1)'(clone_q ? 2 : 1);
        ovalid_d = 1'b1;
        ocount_d = sum[sam_pkg::CountW] ? sam_pkg::CountMax : sum[sam_pkg::CountW-1:0];
        ofull_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sam_pkg::S_CLEAR;
      clr_q    <= '0;
      cnt_q    <= (SW + 1)'(1);
      last_q   <= Root;
      total_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      cnt_q    <= cnt_d;
      last_q   <= last_d;
      total_q  <= total_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d; k_q <= k_d; p_q <= p_d; q_q <= q_d; cur_q <= cur_d; nq_q <= nq_d;
    lenp_q <= lenp_d; lencur_q <= lencur_d; linklen_q <= linklen_d; clone_q <= clone_d;
    ocount_q <= ocount_d; ofull_q <= ofull_d;
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> state_q == sam_pkg::S_IDLE) else $error("ready outside idle");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sam_pkg::S_CLEAR |-> !ovalid_q) else $error("result during clear");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= NumStates - 1) else $error("state count overrun");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != sam_pkg::S_CLEAR && tr_we) |-> tr_waddr != tr_raddr)
    else $error("transition read and write collide");

endmodule
